/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define JCB_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define JCB_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define JCB_ASSERT_IMP(label, clk, rst, pre, post, msg)
`define JCB_ASSERT_NXT(label, clk, rst, pre, post, msg)
`endif

`endif

/* hdl/jcb_pkg.sv */
package jcb_pkg;

   localparam logic [7:0] ChSlash  = 8'h2F;
   localparam logic [7:0] ChStar   = 8'h2A;
   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChNul    = 8'h00;

   localparam int QueueDepth = 8;
   localparam int QueueAw    = $clog2(QueueDepth);
   localparam int QueueCw    = QueueAw + 1;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_LINE  = 2'd1,
      MODE_BLOCK = 2'd2
   } mode_type;

   typedef struct packed {
      logic [15:0] prev;
      logic [1:0]  pos;
      logic        quoted;
      mode_type    mode;
      logic        skip;
   } scan_state_type;

   localparam scan_state_type ScanReset = '{
      prev: 16'h0000, pos: 2'd0, quoted: 1'b0, mode: MODE_NONE, skip: 1'b0
   };

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rsp_item_type;

   function automatic logic [7:0] blank_byte(input logic [7:0] c);
      logic [7:0] r;
      r = ChSpace;
      if (c inside {ChSpace, [8'h09:8'h0D]}) r = c;
      return r;
   endfunction

endpackage

/* hdl/jcb_examine.sv */
module jcb_examine (
   input  jcb_pkg::scan_state_type st_i,
   input  logic [7:0]              c_i,
   input  logic [7:0]              n_i,
   output jcb_pkg::scan_state_type st_o,
   output logic [7:0]              byte_o
);

   logic [7:0] p1;
   logic [7:0] p2;
   logic       escaped;
   logic       is_none;
   logic       is_line;

   assign p1      = st_i.prev[7:0];
   assign p2      = st_i.prev[15:8];
   assign escaped = (st_i.pos >= 2'd2) && (p1 == jcb_pkg::ChBslash)
                    && (p2 != jcb_pkg::ChBslash);
   assign is_none = (st_i.mode == jcb_pkg::MODE_NONE);
   assign is_line = (st_i.mode == jcb_pkg::MODE_LINE);

   always_comb begin
      st_o   = st_i;
      byte_o = c_i;
      if (st_i.skip) begin
         st_o.skip = 1'b0;
         byte_o    = jcb_pkg::blank_byte(c_i);
      end else begin
         if (is_none && c_i == jcb_pkg::ChQuote && !escaped) st_o.quoted = ~st_i.quoted;
         if (st_o.quoted) begin
            byte_o = c_i;
         end else if (is_none && c_i == jcb_pkg::ChSlash && n_i == jcb_pkg::ChSlash) begin
            st_o.mode = jcb_pkg::MODE_LINE;
            st_o.skip = 1'b1;
            byte_o    = jcb_pkg::blank_byte(c_i);
         end else if (is_line && c_i == jcb_pkg::ChCr && n_i == jcb_pkg::ChLf) begin
            st_o.mode = jcb_pkg::MODE_NONE;
            st_o.skip = 1'b1;
            byte_o    = jcb_pkg::blank_byte(c_i);
         end else if (is_line && c_i == jcb_pkg::ChLf) begin
            st_o.mode = jcb_pkg::MODE_NONE;
            byte_o    = c_i;
         end else if (is_none && c_i == jcb_pkg::ChSlash && n_i == jcb_pkg::ChStar) begin
            st_o.mode = jcb_pkg::MODE_BLOCK;
            st_o.skip = 1'b1;
            byte_o    = jcb_pkg::blank_byte(c_i);
         end else if (!is_none && !is_line && c_i == jcb_pkg::ChStar
                      && n_i == jcb_pkg::ChSlash) begin
            st_o.mode = jcb_pkg::MODE_NONE;
            st_o.skip = 1'b1;
            byte_o    = jcb_pkg::blank_byte(c_i);
         end else begin
            byte_o = is_none ? c_i : jcb_pkg::blank_byte(c_i);
         end
      end
      st_o.prev = {st_i.prev[7:0], c_i};
      if (st_i.pos < 2'd2) st_o.pos = st_i.pos + 2'd1;
   end

endmodule

/* hdl/jcb_queue.sv */
module jcb_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       push_n,
   input  jcb_pkg::rsp_item_type            push0,
   input  jcb_pkg::rsp_item_type            push1,
   input  logic                             out_stall,
   output logic                             out_valid,
   output jcb_pkg::rsp_item_type            out_item,
   output logic [jcb_pkg::QueueCw-1:0]      count
);

   jcb_pkg::rsp_item_type mem_ff [jcb_pkg::QueueDepth];
   logic [jcb_pkg::QueueAw-1:0] head_ff, head_in;
   logic [jcb_pkg::QueueAw-1:0] tail_ff, tail_in;
   logic [jcb_pkg::QueueCw-1:0] cnt_ff, cnt_in;
   logic                        pop;

   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[head_ff];
   assign count     = cnt_ff;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      head_in = head_ff + jcb_pkg::QueueAw'(pop);
      tail_in = tail_ff + jcb_pkg::QueueAw'(push_n);
      cnt_in  = cnt_ff + jcb_pkg::QueueCw'(push_n) - jcb_pkg::QueueCw'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[tail_ff] <= push0;
      if (push_n == 2'd2) mem_ff[tail_ff + jcb_pkg::QueueAw'(1)] <= push1;
   end

endmodule

/* hdl/json_comment_blanker_top.sv */
// Channel  Ports                          Direction  Moves
// request  req_valid/req_stall, req_in_*  in         one text byte per item
// response rsp_valid/rsp_stall, rsp_out_* out        one blanked byte per item
//
// Accepts one item per cycle while req_stall is low; an item is registered, examined
// combinationally against the next byte, and queued in an 8-entry result queue read by
// the response channel. A byte comes out once the byte after it has been accepted (or
// without waiting for one when it is last); a last item yields up to two results.
// Synchronous active-high reset clears the scan state and empties the queue.
// req_stall rises when the queue could not take two results for each item in flight and two more for a new one.
`include "assert_macros.svh"
module json_comment_blanker_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic [7:0]              in_byte_ff;
   logic                    in_last_ff;
   logic                    in_vld_ff, in_vld_in;
   logic [7:0]              held_byte_ff, held_byte_in;
   logic                    held_valid_ff, held_valid_in;
   jcb_pkg::scan_state_type st_ff, st_in;
   jcb_pkg::scan_state_type st_a, st_mid, st_b;
   logic [7:0]              out0, out1;
   logic [1:0]              push_n;
   jcb_pkg::rsp_item_type   push0, push1, q_item;
   logic [jcb_pkg::QueueCw-1:0] q_count;
   logic [jcb_pkg::QueueCw:0]   need;

   assign need      = (jcb_pkg::QueueCw+1)'(q_count) + (in_vld_ff ? (jcb_pkg::QueueCw+1)'(2)
                                                                  : '0);
   assign req_stall = need > (jcb_pkg::QueueCw+1)'(jcb_pkg::QueueDepth - 2);
   assign in_vld_in = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (in_vld_in) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   jcb_examine u_exam_held (
      .st_i(st_ff), .c_i(held_byte_ff), .n_i(in_byte_ff), .st_o(st_a), .byte_o(out0)
   );

   assign st_mid = held_valid_ff ? st_a : st_ff;

   jcb_examine u_exam_last (
      .st_i(st_mid), .c_i(in_byte_ff), .n_i(jcb_pkg::ChNul), .st_o(st_b), .byte_o(out1)
   );

   always_comb begin
      st_in         = st_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      push_n        = 2'd0;
      push0         = held_valid_ff ? jcb_pkg::rsp_item_type'{data: out0, last: 1'b0}
                                    : jcb_pkg::rsp_item_type'{data: out1, last: 1'b1};
      push1         = jcb_pkg::rsp_item_type'{data: out1, last: 1'b1};
      if (in_vld_ff) begin
         if (in_last_ff) begin
            push_n        = held_valid_ff ? 2'd2 : 2'd1;
            st_in         = jcb_pkg::ScanReset;
            held_valid_in = 1'b0;
         end else begin
            push_n        = held_valid_ff ? 2'd1 : 2'd0;
            st_in         = st_mid;
            held_byte_in  = in_byte_ff;
            held_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         held_valid_ff <= 1'b0;
         st_ff         <= jcb_pkg::ScanReset;
      end else begin
         in_vld_ff     <= in_vld_in;
         held_valid_ff <= held_valid_in;
         st_ff         <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

   jcb_queue u_queue (
      .clock(clock), .reset(reset), .push_n(push_n), .push0(push0), .push1(push1),
      .out_stall(rsp_stall), .out_valid(rsp_valid), .out_item(q_item), .count(q_count)
   );

   assign rsp_out_byte = q_item.data;
   assign rsp_out_last = q_item.last;

   `JCB_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, q_count <= jcb_pkg::QueueCw'(jcb_pkg::QueueDepth), "result queue overflow")
   `JCB_ASSERT_NXT(a_last_clears, clock, reset, in_vld_ff && in_last_ff, !held_valid_ff && st_ff == jcb_pkg::ScanReset, "stream state not cleared after last item")
   `JCB_ASSERT_IMP(a_idle_state, clock, reset, !held_valid_ff, st_ff == jcb_pkg::ScanReset, "scan state active with nothing held")
   `JCB_ASSERT_NXT(a_last_output, clock, reset, in_vld_ff && in_last_ff, rsp_valid, "last item produced no result")

endmodule
